FILE: rtl/first_fit_sorted_region_allocator_unit_macros.svh
// Assertion macros used by the allocator checker
`ifndef FIRST_FIT_SORTED_REGION_ALLOCATOR_UNIT_MACROS_SVH
`define FIRST_FIT_SORTED_REGION_ALLOCATOR_UNIT_MACROS_SVH

// same-cycle implication, quiet while in reset
`define FFA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, quiet while in reset
`define FFA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/ffa_pkg.sv
// Package: constants, codes, types and helpers of the region allocator
`timescale 1ns / 1ps
`default_nettype none

package ffa_pkg;

  localparam int MAX_ENTRIES  = 64;
  localparam int HEADER_BYTES = 4096;

  localparam int WORD_W = 32;
  localparam int SUM_W  = WORD_W + 2;
  localparam int OP_W   = 2;
  localparam int ST_W   = 3;
  localparam int USE_W  = 7;
  localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
  localparam int IDX_W  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

  localparam logic [WORD_W-1:0] SEG_RESET = 32'd16777216;

  localparam logic [OP_W-1:0] OP_ALLOC = 2'd0;
  localparam logic [OP_W-1:0] OP_FREE  = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

  localparam logic [ST_W-1:0] ST_OK          = 3'd0;
  localparam logic [ST_W-1:0] ST_ZERO_LENGTH = 3'd1;
  localparam logic [ST_W-1:0] ST_TABLE_FULL  = 3'd2;
  localparam logic [ST_W-1:0] ST_NO_SPACE    = 3'd3;
  localparam logic [ST_W-1:0] ST_NOT_FOUND   = 3'd4;

  typedef struct packed {
    logic [WORD_W-1:0] start;
    logic [WORD_W-1:0] length;
  } entry_t;

  typedef struct packed {
    logic [OP_W-1:0]   operation;
    logic [WORD_W-1:0] request_length;
    logic [WORD_W-1:0] release_offset;
  } req_t;

  typedef struct packed {
    logic [ST_W-1:0]   status;
    logic [WORD_W-1:0] granted_offset;
    logic [USE_W-1:0]  entries_in_use;
  } res_t;

  typedef struct packed {
    logic [SUM_W-1:0] add_a;
    logic [SUM_W-1:0] add_b;
    logic [SUM_W-1:0] cmp_a;
    logic [SUM_W-1:0] cmp_b;
  } alu_in_t;

  typedef struct packed {
    logic [SUM_W-1:0] sum;
    logic             gt;
    logic             eq;
  } alu_out_t;

  function automatic logic [USE_W-1:0] to_in_use(input logic [CNT_W-1:0] cnt);
    logic [CNT_W+USE_W-1:0] wide;
    wide = {{USE_W{1'b0}}, cnt};
    return wide[USE_W-1:0];
  endfunction

endpackage

`default_nettype wire

FILE: rtl/ffa_ifs.sv
// Interfaces: request, result and segment-size configuration channels
`timescale 1ns / 1ps
`default_nettype none

interface ffa_req_if;
  logic                             valid;
  logic                             ready;
  logic [ffa_pkg::OP_W-1:0]         operation;
  logic [ffa_pkg::WORD_W-1:0]       request_length;
  logic [ffa_pkg::WORD_W-1:0]       release_offset;

  modport source (output valid, operation, request_length, release_offset, input ready);
  modport sink   (input valid, operation, request_length, release_offset, output ready);
endinterface

interface ffa_res_if;
  logic                             valid;
  logic                             ready;
  logic [ffa_pkg::ST_W-1:0]         status;
  logic [ffa_pkg::WORD_W-1:0]       granted_offset;
  logic [ffa_pkg::USE_W-1:0]        entries_in_use;

  modport source (output valid, status, granted_offset, entries_in_use, input ready);
  modport sink   (input valid, status, granted_offset, entries_in_use, output ready);
endinterface

interface ffa_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [ffa_pkg::WORD_W-1:0]       segment_size;

  modport source (output valid, segment_size, input ready);
  modport sink   (input valid, segment_size, output ready);
endinterface

`default_nettype wire

FILE: rtl/ffa_alu.sv
// Shared add and compare unit used by the table sequencer
`timescale 1ns / 1ps
`default_nettype none

module ffa_alu (
  input  ffa_pkg::alu_in_t  alu_in,
  output ffa_pkg::alu_out_t alu_out
);

  always_comb begin
    alu_out.sum = alu_in.add_a + alu_in.add_b;
    alu_out.gt  = alu_in.cmp_a > alu_in.cmp_b;
    alu_out.eq  = alu_in.cmp_a == alu_in.cmp_b;
  end

endmodule

`default_nettype wire

FILE: rtl/ffa_engine.sv
// Sequencer and entry table: first-fit scan, insert, remove and clear
`timescale 1ns / 1ps
`default_nettype none

module ffa_engine (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  ffa_pkg::req_t               req,
  input  logic [ffa_pkg::WORD_W-1:0]  segment_size,
  output logic                        idle,
  input  logic                        res_ready,
  output logic                        res_valid,
  output ffa_pkg::res_t               res
);

  typedef enum logic [3:0] {
    S_IDLE, S_INIT, S_AFIT, S_AADV, S_LIM, S_SHR, S_SHW, S_WINS,
    S_FRD, S_FCMP, S_FSR, S_FSW, S_DONE
  } state_t;

  state_t                       state_r, state_nxt;
  logic [ffa_pkg::CNT_W-1:0]    count_r, count_nxt;
  logic [ffa_pkg::CNT_W-1:0]    idx_r, idx_nxt;
  logic [ffa_pkg::CNT_W-1:0]    pos_r, pos_nxt;
  logic [ffa_pkg::SUM_W-1:0]    cursor_r, cursor_nxt;
  logic [ffa_pkg::SUM_W-1:0]    need_r, need_nxt;
  logic [ffa_pkg::SUM_W-1:0]    end_r, end_nxt;
  logic [ffa_pkg::WORD_W-1:0]   len_r, len_nxt;
  logic [ffa_pkg::WORD_W-1:0]   off_r, off_nxt;
  logic [ffa_pkg::ST_W-1:0]     status_r, status_nxt;
  logic [ffa_pkg::WORD_W-1:0]   granted_r, granted_nxt;

  ffa_pkg::entry_t              mem [ffa_pkg::MAX_ENTRIES];
  ffa_pkg::entry_t              rd_data_r;
  ffa_pkg::entry_t              wdata;
  logic                         we;
  logic [ffa_pkg::IDX_W-1:0]    waddr;
  logic [ffa_pkg::IDX_W-1:0]    rd_addr;

  logic [ffa_pkg::CNT_W-1:0]    idx_m1;
  logic [ffa_pkg::CNT_W-1:0]    idx_p1;

  ffa_pkg::alu_in_t             alu_in;
  ffa_pkg::alu_out_t            alu_out;

  ffa_alu u_alu (
    .alu_in  (alu_in),
    .alu_out (alu_out)
  );

  assign idx_m1 = idx_r - ffa_pkg::CNT_W'(1);
  assign idx_p1 = idx_r + ffa_pkg::CNT_W'(1);

  always_comb begin
    state_nxt   = state_r;
    count_nxt   = count_r;
    idx_nxt     = idx_r;
    pos_nxt     = pos_r;
    cursor_nxt  = cursor_r;
    need_nxt    = need_r;
    end_nxt     = end_r;
    len_nxt     = len_r;
    off_nxt     = off_r;
    status_nxt  = status_r;
    granted_nxt = granted_r;
    we          = 1'b0;
    waddr       = idx_r[ffa_pkg::IDX_W-1:0];
    wdata       = rd_data_r;
    rd_addr     = idx_r[ffa_pkg::IDX_W-1:0];
    alu_in      = '0;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          len_nxt     = req.request_length;
          off_nxt     = req.release_offset;
          status_nxt  = ffa_pkg::ST_OK;
          granted_nxt = '0;
          idx_nxt     = '0;
          pos_nxt     = count_r;
          cursor_nxt  = ffa_pkg::SUM_W'(ffa_pkg::HEADER_BYTES);
          case (req.operation)
            ffa_pkg::OP_ALLOC: begin
              if (req.request_length == '0) begin
                status_nxt = ffa_pkg::ST_ZERO_LENGTH;
                state_nxt  = S_DONE;
              end else if (count_r >= ffa_pkg::CNT_W'(ffa_pkg::MAX_ENTRIES)) begin
                status_nxt = ffa_pkg::ST_TABLE_FULL;
                state_nxt  = S_DONE;
              end else begin
                state_nxt  = S_INIT;
              end
            end
            ffa_pkg::OP_FREE: begin
              state_nxt = S_FRD;
            end
            ffa_pkg::OP_CLEAR: begin
              count_nxt = '0;
              state_nxt = S_DONE;
            end
            default: begin
              state_nxt = S_DONE;
            end
          endcase
        end
      end
      // need = cursor + length; fetch next entry
      S_INIT: begin
        alu_in.add_a = cursor_r;
        alu_in.add_b = ffa_pkg::SUM_W'(len_r);
        need_nxt     = alu_out.sum;
        if (idx_r == count_r) begin
          state_nxt = S_LIM;
        end else begin
          state_nxt = S_AFIT;
        end
      end
      // gap fits when start >= cursor + length
      S_AFIT: begin
        alu_in.add_a = ffa_pkg::SUM_W'(rd_data_r.start);
        alu_in.add_b = ffa_pkg::SUM_W'(rd_data_r.length);
        alu_in.cmp_a = need_r;
        alu_in.cmp_b = ffa_pkg::SUM_W'(rd_data_r.start);
        if (!alu_out.gt) begin
          pos_nxt   = idx_r;
          state_nxt = S_LIM;
        end else begin
          end_nxt   = alu_out.sum;
          state_nxt = S_AADV;
        end
      end
      S_AADV: begin
        alu_in.cmp_a = end_r;
        alu_in.cmp_b = cursor_r;
        if (alu_out.gt) begin
          cursor_nxt = end_r;
        end
        idx_nxt   = idx_p1;
        state_nxt = S_INIT;
      end
      S_LIM: begin
        alu_in.cmp_a = need_r;
        alu_in.cmp_b = ffa_pkg::SUM_W'(segment_size);
        if (alu_out.gt) begin
          status_nxt = ffa_pkg::ST_NO_SPACE;
          state_nxt  = S_DONE;
        end else begin
          idx_nxt    = count_r;
          state_nxt  = S_SHR;
        end
      end
      // open a slot at pos by moving entries up
      S_SHR: begin
        rd_addr = idx_m1[ffa_pkg::IDX_W-1:0];
        if (idx_r == pos_r) begin
          state_nxt = S_WINS;
        end else begin
          state_nxt = S_SHW;
        end
      end
      S_SHW: begin
        we        = 1'b1;
        idx_nxt   = idx_m1;
        state_nxt = S_SHR;
      end
      S_WINS: begin
        we           = 1'b1;
        waddr        = pos_r[ffa_pkg::IDX_W-1:0];
        wdata.start  = cursor_r[ffa_pkg::WORD_W-1:0];
        wdata.length = len_r;
        count_nxt    = count_r + ffa_pkg::CNT_W'(1);
        granted_nxt  = cursor_r[ffa_pkg::WORD_W-1:0];
        state_nxt    = S_DONE;
      end
      S_FRD: begin
        if (idx_r == count_r) begin
          status_nxt = ffa_pkg::ST_NOT_FOUND;
          state_nxt  = S_DONE;
        end else begin
          state_nxt  = S_FCMP;
        end
      end
      S_FCMP: begin
        alu_in.cmp_a = ffa_pkg::SUM_W'(rd_data_r.start);
        alu_in.cmp_b = ffa_pkg::SUM_W'(off_r);
        if (alu_out.eq) begin
          state_nxt = S_FSR;
        end else begin
          idx_nxt   = idx_p1;
          state_nxt = S_FRD;
        end
      end
      // close the hole by moving entries down
      S_FSR: begin
        rd_addr = idx_p1[ffa_pkg::IDX_W-1:0];
        if (idx_p1 == count_r) begin
          count_nxt = count_r - ffa_pkg::CNT_W'(1);
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_FSW;
        end
      end
      S_FSW: begin
        we        = 1'b1;
        idx_nxt   = idx_p1;
        state_nxt = S_FSR;
      end
      S_DONE: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
    idx_r     <= idx_nxt;
    pos_r     <= pos_nxt;
    cursor_r  <= cursor_nxt;
    need_r    <= need_nxt;
    end_r     <= end_nxt;
    len_r     <= len_nxt;
    off_r     <= off_nxt;
    status_r  <= status_nxt;
    granted_r <= granted_nxt;
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign idle               = (state_r == S_IDLE);
  assign res_valid          = (state_r == S_DONE);
  assign res.status         = status_r;
  assign res.granted_offset = granted_r;
  assign res.entries_in_use = ffa_pkg::to_in_use(count_r);

endmodule

`default_nettype wire

FILE: rtl/first_fit_sorted_region_allocator_unit.sv
// Top level: channels, segment-size register, result register, sequencer
// Requests are taken one at a time: a new request is accepted only once the sequencer is idle again.
// Allocate: scans entries in order for the first gap that fits, then moves later entries up and inserts.
// Free: scans entries for a matching start, then moves later entries down; clear resets the entry count.
// The sequencer uses a single table read port and the shared add/compare unit; a stalled result holds it in done.
// Reset: sequencer, entry count, result valid cleared; segment_size 16777216; table kept.
`timescale 1ns / 1ps
`default_nettype none

module first_fit_sorted_region_allocator_unit (
  input  logic      clk,
  input  logic      rst_n,
  ffa_req_if.sink   in_chan,
  ffa_res_if.source out_chan,
  ffa_cfg_if.sink   cfg_chan
);

  logic [ffa_pkg::WORD_W-1:0] seg_r, seg_nxt;
  logic                       out_valid_r, out_valid_nxt;
  ffa_pkg::res_t              out_r, out_nxt;

  ffa_pkg::req_t              req;
  ffa_pkg::res_t              res;
  logic                       eng_idle;
  logic                       res_valid;
  logic                       res_ready;
  logic                       start;

  assign req.operation      = in_chan.operation;
  assign req.request_length = in_chan.request_length;
  assign req.release_offset = in_chan.release_offset;

  assign in_chan.ready  = eng_idle;
  assign start          = in_chan.valid && eng_idle;
  assign cfg_chan.ready = 1'b1;
  assign res_ready      = !out_valid_r || out_chan.ready;

  ffa_engine u_engine (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .req          (req),
    .segment_size (seg_r),
    .idle         (eng_idle),
    .res_ready    (res_ready),
    .res_valid    (res_valid),
    .res          (res)
  );

  always_comb begin
    seg_nxt       = seg_r;
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    if (cfg_chan.valid) begin
      seg_nxt = cfg_chan.segment_size;
    end
    if (out_valid_r && out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (res_valid && res_ready) begin
      out_valid_nxt = 1'b1;
      out_nxt       = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seg_r       <= ffa_pkg::SEG_RESET;
      out_valid_r <= 1'b0;
    end else begin
      seg_r       <= seg_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_r <= out_nxt;
  end

  assign out_chan.valid          = out_valid_r;
  assign out_chan.status         = out_r.status;
  assign out_chan.granted_offset = out_r.granted_offset;
  assign out_chan.entries_in_use = out_r.entries_in_use;

endmodule

`default_nettype wire

FILE: rtl/ffa_checker.sv
// Port-level checker for the allocator, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
`include "first_fit_sorted_region_allocator_unit_macros.svh"

module ffa_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [ffa_pkg::ST_W-1:0]    status,
  input logic [ffa_pkg::WORD_W-1:0]  granted_offset,
  input logic [ffa_pkg::USE_W-1:0]   entries_in_use
);

  `FFA_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result item dropped while stalled")
  `FFA_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(status) && $stable(granted_offset) && $stable(entries_in_use), "stalled result item changed")
  `FFA_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "item taken while one is in work")
  `FFA_ASSERT_IMP(a_status_code, out_valid, status <= ffa_pkg::ST_NOT_FOUND, "undefined status code")
  `FFA_ASSERT_IMP(a_grant_zero, out_valid && (status != ffa_pkg::ST_OK), granted_offset == '0, "offset granted on failure")

endmodule

bind first_fit_sorted_region_allocator_unit ffa_checker u_ffa_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_chan.valid),
  .in_ready       (in_chan.ready),
  .out_valid      (out_chan.valid),
  .out_ready      (out_chan.ready),
  .status         (out_chan.status),
  .granted_offset (out_chan.granted_offset),
  .entries_in_use (out_chan.entries_in_use)
);

`default_nettype wire
